// ===== sv/pf_pkg.sv =====
// Shared types, constants and helpers for the Playfair encipher block.
// Used by pf_front, pf_queue, pf_back and the top level; depends on nothing.
`default_nettype none

package pf_pkg;

  // Square geometry and alphabet
  localparam int unsigned CELLS     = 25;
  localparam int unsigned SIDE      = 5;
  localparam int unsigned QUEUE_DEP = 2;
  localparam int unsigned QPTR_W    = (QUEUE_DEP > 1) ? $clog2(QUEUE_DEP) : 1;
  localparam int unsigned QCNT_W    = $clog2(QUEUE_DEP + 1);

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_Q   = 5'd16;
  localparam letter_t LETTER_X   = 5'd23;
  localparam letter_t LETTER_Z   = 5'd25;
  localparam coord_t  LAST_COORD = 3'(SIDE - 1);
  localparam letter_t FULL_COUNT = 5'(CELLS);

  // ASCII bounds
  localparam logic [7:0] ASC_UP_A  = 8'h41;
  localparam logic [7:0] ASC_UP_Z  = 8'h5A;
  localparam logic [7:0] ASC_LO_A  = 8'h61;
  localparam logic [7:0] ASC_LO_Z  = 8'h7A;
  localparam logic [6:0] ASC_BASE  = 7'h41;

  // Input action codes
  typedef enum logic [2:0] {
    ACT_NEW_KEY   = 3'd0,
    ACT_KEY_BYTE  = 3'd1,
    ACT_END_KEY   = 3'd2,
    ACT_TEXT_BYTE = 3'd3,
    ACT_END_TEXT  = 3'd4
  } action_e;

  // Classified commands held in the queue
  typedef enum logic [2:0] {
    OP_NEW_KEY,
    OP_KEY_LETTER,
    OP_END_KEY,
    OP_TEXT_LETTER,
    OP_END_TEXT
  } op_e;

  typedef struct packed {
    op_e     op;
    letter_t letter;
  } cmd_t;

  // Front to queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_POS,
    BK_SQR
  } back_state_e;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } cell_t;

  // Linear cell index: row * 5 + col
  function automatic letter_t cell_index(cell_t c);
    return {c.row[2:0], 2'b00} + {2'b00, c.row} + {2'b00, c.col};
  endfunction

  // Step one place along a row or column, wrapping
  function automatic coord_t next_coord(coord_t c);
    return (c == LAST_COORD) ? 3'd0 : c + 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pf_front.sv =====
// Front end: classifies one accepted input word into a queue command.
// Depends on pf_pkg.
`default_nettype none

module pf_front (
  input  logic          in_fire_i,
  input  logic [2:0]    action_i,
  input  logic [7:0]    char_byte_i,
  output pf_pkg::push_t push_o
);
  import pf_pkg::*;

  logic    is_lower;
  logic    is_upper;
  logic    is_letter;
  letter_t code;
  logic    keep;
  op_e     op;

  // Fold case and map to letter code
  always_comb begin
    is_lower  = (char_byte_i >= ASC_LO_A) && (char_byte_i <= ASC_LO_Z);
    is_upper  = (char_byte_i >= ASC_UP_A) && (char_byte_i <= ASC_UP_Z);
    is_letter = is_lower || is_upper;
    code      = 5'(char_byte_i - (is_lower ? ASC_LO_A : ASC_UP_A));
  end

  // Drop words that can never change state: non-letters, Q, unused codes
  always_comb begin
    keep = 1'b0;
    op   = OP_NEW_KEY;
    unique case (action_i)
      ACT_NEW_KEY: begin
        keep = 1'b1;
        op   = OP_NEW_KEY;
      end
      ACT_KEY_BYTE: begin
        keep = is_letter && (code != LETTER_Q);
        op   = OP_KEY_LETTER;
      end
      ACT_END_KEY: begin
        keep = 1'b1;
        op   = OP_END_KEY;
      end
      ACT_TEXT_BYTE: begin
        keep = is_letter && (code != LETTER_Q);
        op   = OP_TEXT_LETTER;
      end
      ACT_END_TEXT: begin
        keep = 1'b1;
        op   = OP_END_TEXT;
      end
      default: begin
        keep = 1'b0;
        op   = OP_NEW_KEY;
      end
    endcase
  end

  assign push_o.valid      = in_fire_i && keep;
  assign push_o.cmd.op     = op;
  assign push_o.cmd.letter = code;

endmodule

`default_nettype wire

// ===== sv/pf_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on pf_pkg.
`default_nettype none

module pf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pf_pkg::push_t push_i,
  output logic          full_o,
  input  logic          pop_i,
  output pf_pkg::head_t head_o
);
  import pf_pkg::*;

  cmd_t                mem_q [QUEUE_DEP];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEP - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEP));
  assign head_o.avail = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.avail;

  // Store pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= bump(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + QCNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/pf_back.sv =====
// Back end: builds the key square and enciphers digraphs, with result register.
// Depends on pf_pkg.
`default_nettype none

module pf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pf_pkg::head_t head_i,
  output logic          pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [6:0]    res_first_o,
  output logic [6:0]    res_second_o
);
  import pf_pkg::*;

  back_state_e state_q, state_d;

  logic [25:0] used_q;
  letter_t     fill_q;
  cell_t       fill_cell_q;
  letter_t     walk_q;
  letter_t     pend_q;
  logic        pend_vld_q;
  logic        out_vld_q;
  logic [6:0]  first_q, second_q;

  // Square and position stores
  letter_t     sq_mem  [CELLS];
  cell_t       pos_mem [26];
  cell_t       pos_a_q, pos_b_q;
  letter_t     sq_a_q, sq_b_q;

  logic        full;
  logic        new_key, place_en, walk_start, walk_step;
  logic        pos_rd, sq_rd, load_out, pend_set, pend_clr;
  letter_t     place_letter, rd_a, rd_b;
  cell_t       na, nb;

  assign full = (fill_q == FULL_COUNT);

  // Next state and control
  always_comb begin
    state_d      = state_q;
    pop_o        = 1'b0;
    new_key      = 1'b0;
    place_en     = 1'b0;
    place_letter = head_i.cmd.letter;
    walk_start   = 1'b0;
    walk_step    = 1'b0;
    pos_rd       = 1'b0;
    rd_a         = pend_q;
    rd_b         = LETTER_X;
    sq_rd        = 1'b0;
    load_out     = 1'b0;
    pend_set     = 1'b0;
    pend_clr     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (head_i.avail) begin
          pop_o = 1'b1;
          case (head_i.cmd.op)
            OP_NEW_KEY: new_key = 1'b1;
            OP_KEY_LETTER: begin
              place_en = !used_q[head_i.cmd.letter] && !full;
            end
            OP_END_KEY: begin
              walk_start = 1'b1;
              state_d    = BK_FILL;
            end
            OP_TEXT_LETTER: begin
              if (full) begin
                if (!pend_vld_q) begin
                  pend_set = 1'b1;
                end else if (head_i.cmd.letter == pend_q) begin
                  pos_rd  = 1'b1;
                  rd_a    = head_i.cmd.letter;
                  state_d = BK_POS;
                end else begin
                  pos_rd   = 1'b1;
                  rd_b     = head_i.cmd.letter;
                  pend_clr = 1'b1;
                  state_d  = BK_POS;
                end
              end
            end
            OP_END_TEXT: begin
              if (full && pend_vld_q) begin
                pos_rd   = 1'b1;
                pend_clr = 1'b1;
                state_d  = BK_POS;
              end
            end
            default: ;
          endcase
        end
      end
      BK_FILL: begin
        // Walk A..Z, one letter a cycle, placing unused ones
        walk_step    = 1'b1;
        place_letter = walk_q;
        place_en     = !full && !used_q[walk_q];
        if (full || (walk_q == LETTER_Z)) state_d = BK_IDLE;
      end
      BK_POS: begin
        sq_rd   = 1'b1;
        state_d = BK_SQR;
      end
      BK_SQR: begin
        if (!out_vld_q || res_ready_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Playfair rule on the registered positions
  always_comb begin
    if (pos_a_q.row == pos_b_q.row) begin
      na = '{row: pos_a_q.row, col: next_coord(pos_a_q.col)};
      nb = '{row: pos_b_q.row, col: next_coord(pos_b_q.col)};
    end else if (pos_a_q.col == pos_b_q.col) begin
      na = '{row: next_coord(pos_a_q.row), col: pos_a_q.col};
      nb = '{row: next_coord(pos_b_q.row), col: pos_b_q.col};
    end else begin
      na = '{row: pos_a_q.row, col: pos_b_q.col};
      nb = '{row: pos_b_q.row, col: pos_a_q.col};
    end
  end

  // Stores, read registers and result payload
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[cell_index(fill_cell_q)] <= place_letter;
      pos_mem[place_letter]           <= fill_cell_q;
    end
    if (pos_rd) begin
      pos_a_q <= pos_mem[rd_a];
      pos_b_q <= pos_mem[rd_b];
    end
    if (sq_rd) begin
      sq_a_q <= sq_mem[cell_index(na)];
      sq_b_q <= sq_mem[cell_index(nb)];
    end
    if (load_out) begin
      first_q  <= ASC_BASE + {2'b00, sq_a_q};
      second_q <= ASC_BASE + {2'b00, sq_b_q};
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      used_q      <= 26'(1) << LETTER_Q;
      fill_q      <= '0;
      fill_cell_q <= '0;
      walk_q      <= '0;
      pend_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (new_key) begin
        used_q      <= 26'(1) << LETTER_Q;
        fill_q      <= '0;
        fill_cell_q <= '0;
        pend_vld_q  <= 1'b0;
      end else if (place_en) begin
        used_q[place_letter] <= 1'b1;
        fill_q               <= fill_q + 5'd1;
        if (fill_cell_q.col == LAST_COORD) begin
          fill_cell_q.col <= '0;
          fill_cell_q.row <= fill_cell_q.row + 3'd1;
        end else begin
          fill_cell_q.col <= fill_cell_q.col + 3'd1;
        end
      end
      if (walk_start)     walk_q <= '0;
      else if (walk_step) walk_q <= walk_q + 5'd1;
      if (pend_set) begin
        pend_q     <= head_i.cmd.letter;
        pend_vld_q <= 1'b1;
      end else if (pend_clr) begin
        pend_vld_q <= 1'b0;
      end
      if (load_out)         out_vld_q <= 1'b1;
      else if (res_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign res_valid_o  = out_vld_q;
  assign res_first_o  = first_q;
  assign res_second_o = second_q;

endmodule

`default_nettype wire

// ===== sv/playfair_encipher.sv =====
// Playfair encipher top level: front classifier, command queue, back end.
// Depends on pf_pkg, pf_front, pf_queue and pf_back.
//
//  channel   direction  tdata fields (low bit up)                tlast/tuser
//  s_axis    in         action[2:0], char_byte[10:3], zero pad   none
//  m_axis    out        cipher_first[6:0], cipher_second[13:7]   none
//
// A word is taken whenever the two-entry command queue has room.
// The back end handles a key or control word in its idle state; a digraph
// passes a position read, a square read and the result register; end of key
// takes the word, then walks over the alphabet at one letter a cycle until
// the square is full or Z is reached.
// A stalled result holds in the output register; the back end then waits.
// Reset clears the queue, the key state and the output valid at once.
`default_nettype none

module playfair_encipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // action[2:0], char_byte[10:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // cipher_first[6:0], cipher_second[13:7]
);
  import pf_pkg::*;

  push_t      push;
  head_t      head;
  logic       q_full;
  logic       pop;
  logic [6:0] res_first, res_second;

  assign s_axis_tready = !q_full;

  pf_front u_front (
    .in_fire_i   (s_axis_tvalid && s_axis_tready),
    .action_i    (s_axis_tdata[2:0]),
    .char_byte_i (s_axis_tdata[10:3]),
    .push_o      (push)
  );

  pf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  pf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_first_o  (res_first),
    .res_second_o (res_second)
  );

  assign m_axis_tdata = {2'b00, res_second, res_first};

endmodule

`default_nettype wire

// ===== sv/pf_checker.sv =====
// Port-level checks for playfair_encipher, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module pf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  localparam logic [6:0] CH_A = 7'h41;
  localparam logic [6:0] CH_Z = 7'h5A;
  localparam logic [6:0] CH_Q = 7'h51;

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // Ciphertext letters are uppercase
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] >= CH_A) && (m_axis_tdata[6:0] <= CH_Z)
                   && (m_axis_tdata[13:7] >= CH_A) && (m_axis_tdata[13:7] <= CH_Z))
    else $error("ciphertext letter out of range");

  // The square never holds Q
  a_no_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] != CH_Q) && (m_axis_tdata[13:7] != CH_Q))
    else $error("ciphertext contains Q");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind playfair_encipher pf_checker u_pf_checker (.*);

`default_nettype wire

// ===== sim/tb_playfair_encipher.sv =====
// Self-checking testbench for playfair_encipher: drives key and text words,
// predicts every enciphered digraph and checks the result stream in order.
// Depends on pf_pkg and the playfair_encipher RTL only.

module tb_playfair_encipher;
  timeunit 1ns;
  timeprecision 1ps;

  import pf_pkg::*;

  // Action codes the block ignores
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam letter_t    NOT_LETTER   = 5'd26;

  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned CALM_FROM    = 800;
  localparam int unsigned CALM_TO      = 1400;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 620;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] chr;
  } word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // action[2:0], char_byte[10:3]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // cipher_first[6:0], cipher_second[13:7]

  word_t       word_backlog [$];
  logic [13:0] cipher_due [$];       // {second, first} per digraph
  logic        took_word = 1'b0;
  int unsigned cyc       = 0;
  int unsigned quiet     = 0;
  int unsigned errors    = 0;
  logic        calm;

  // Shadow copy of the square and the digraph state
  letter_t     sq_cell [CELLS];
  letter_t     cell_of [26];
  logic [25:0] placed  = 26'd1 << LETTER_Q;
  int unsigned filled  = 0;
  letter_t     held    = '0;
  logic        held_ok = 1'b0;

  playfair_encipher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  function automatic letter_t letter_code(logic [7:0] b);
    if (b >= ASC_LO_A && b <= ASC_LO_Z) return letter_t'(b - ASC_LO_A);
    if (b >= ASC_UP_A && b <= ASC_UP_Z) return letter_t'(b - ASC_UP_A);
    return NOT_LETTER;
  endfunction

  // Either case at random
  function automatic logic [7:0] letter_ascii(letter_t l);
    return ($urandom_range(1) ? ASC_LO_A : ASC_UP_A) + 8'(l);
  endfunction

  task automatic place_letter(letter_t l);
    if (filled < CELLS) begin
      sq_cell[filled] = l;
      cell_of[l]      = letter_t'(filled);
      placed[l]       = 1'b1;
      filled++;
    end
  endtask

  // Row shift, column shift or rectangle corners; returns {second, first}
  function automatic logic [13:0] cipher_pair(letter_t p, letter_t s);
    int unsigned a, b, ra, ca, rb, cb, na, nb;
    a  = cell_of[p];
    b  = cell_of[s];
    ra = a / SIDE;
    ca = a % SIDE;
    rb = b / SIDE;
    cb = b % SIDE;
    if (ra == rb) begin
      na = ra * SIDE + (ca + 1) % SIDE;
      nb = rb * SIDE + (cb + 1) % SIDE;
    end else if (ca == cb) begin
      na = ((ra + 1) % SIDE) * SIDE + ca;
      nb = ((rb + 1) % SIDE) * SIDE + cb;
    end else begin
      na = ra * SIDE + cb;
      nb = rb * SIDE + ca;
    end
    return {ASC_BASE + 7'(sq_cell[nb]), ASC_BASE + 7'(sq_cell[na])};
  endfunction

  // Advance the shadow state by one accepted word
  task automatic predict_word(logic [2:0] act, logic [7:0] chr);
    letter_t l;
    l = letter_code(chr);
    case (act)
      ACT_NEW_KEY: begin
        placed  = 26'd1 << LETTER_Q;
        filled  = 0;
        held_ok = 1'b0;
      end
      ACT_KEY_BYTE: begin
        if (l != NOT_LETTER && !placed[l]) place_letter(l);
      end
      ACT_END_KEY: begin
        for (int i = 0; i < 26; i++) begin
          if (!placed[i]) place_letter(letter_t'(i));
        end
      end
      ACT_TEXT_BYTE: begin
        if (filled == CELLS && l != NOT_LETTER && l != LETTER_Q) begin
          if (!held_ok) begin
            held    = l;
            held_ok = 1'b1;
          end else if (l == held) begin
            cipher_due.push_back(cipher_pair(l, LETTER_X));
          end else begin
            cipher_due.push_back(cipher_pair(held, l));
            held_ok = 1'b0;
          end
        end
      end
      ACT_END_TEXT: begin
        if (filled == CELLS && held_ok) begin
          cipher_due.push_back(cipher_pair(held, LETTER_X));
          held_ok = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_pair(logic [13:0] got);
    logic [13:0] want;
    if (cipher_due.size() == 0) begin
      note_error($sformatf("unexpected result %c%c", got[6:0], got[13:7]));
    end else begin
      want = cipher_due.pop_front();
      if (got[6:0] != want[6:0])
        note_error($sformatf("cipher_first expected %c got %c", want[6:0], got[6:0]));
      if (got[13:7] != want[13:7])
        note_error($sformatf("cipher_second expected %c got %c", want[13:7], got[13:7]));
    end
  endtask

  task automatic queue_word(logic [2:0] act, logic [7:0] chr);
    word_t w;
    w.act = act;
    w.chr = chr;
    word_backlog.push_back(w);
  endtask

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_word(s_axis_tdata[2:0], s_axis_tdata[10:3]);
      if (m_axis_tvalid && m_axis_tready) check_pair(m_axis_tdata[13:0]);
      took_word <= s_axis_tvalid && s_axis_tready;
      cyc       <= cyc + 1;
    end
  end

  // Present the next word, or hold the current one until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!s_axis_tvalid || took_word) begin
        if (word_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          s_axis_tdata  <= {5'd0, word_backlog[0].chr, word_backlog[0].act};
          s_axis_tvalid <= 1'b1;
          void'(word_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Drop the run once nothing has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
      quiet <= quiet + 1;
    else
      quiet <= 0;
    if (quiet >= STALL_LIMIT) begin
      $display("tb_playfair_encipher: errors");
      $finish;
    end
  end

  initial begin
    int unsigned counted, key_len, text_len, kind, r, j;
    letter_t     prev, l, tmp;
    letter_t     deck [26];

    // Text, end of text and spare action codes before any square exists
    queue_word(ACT_END_TEXT, 8'h00);
    queue_word(ACT_TEXT_BYTE, "A");
    queue_word(ACT_SPARE_LO, 8'hFF);
    queue_word(ACT_SPARE_HI, 8'h00);
    // Key with mixed case, a space, a digit, Q, a high byte and a repeat
    queue_word(ACT_NEW_KEY, 8'hFF);
    queue_word(ACT_KEY_BYTE, "p");
    queue_word(ACT_KEY_BYTE, "L");
    queue_word(ACT_KEY_BYTE, " ");
    queue_word(ACT_KEY_BYTE, "a");
    queue_word(ACT_KEY_BYTE, "Q");
    queue_word(ACT_KEY_BYTE, "y");
    queue_word(ACT_KEY_BYTE, "3");
    queue_word(ACT_KEY_BYTE, "f");
    queue_word(ACT_KEY_BYTE, 8'hE1);
    queue_word(ACT_KEY_BYTE, "a");
    queue_word(ACT_END_KEY, 8'h00);
    // Square already full: end of key and key bytes change nothing
    queue_word(ACT_END_KEY, 8'hFF);
    queue_word(ACT_KEY_BYTE, "Z");
    // Plain pair, doubled letter, dropped Q and punctuation, padded tail
    queue_word(ACT_TEXT_BYTE, "h");
    queue_word(ACT_TEXT_BYTE, "I");
    queue_word(ACT_TEXT_BYTE, "e");
    queue_word(ACT_TEXT_BYTE, "E");
    queue_word(ACT_TEXT_BYTE, "q");
    queue_word(ACT_TEXT_BYTE, "!");
    queue_word(ACT_END_TEXT, 8'h00);
    // Doubled X, then end of text with and without a held letter
    queue_word(ACT_TEXT_BYTE, "x");
    queue_word(ACT_TEXT_BYTE, "X");
    queue_word(ACT_END_TEXT, 8'h00);
    queue_word(ACT_END_TEXT, 8'h00);

    // Random sessions: mostly well-formed key then text, some broken
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      kind = $urandom_range(9);
      if (kind != 0) begin
        queue_word(ACT_NEW_KEY, 8'($urandom));
        counted++;
        if (kind == 1) begin
          // Whole alphabet as key, shuffled: the square fills from the key alone
          for (int i = 0; i < 26; i++) deck[i] = letter_t'(i);
          for (int i = 25; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = deck[i];
            deck[i] = deck[j];
            deck[j] = tmp;
          end
          for (int i = 0; i < 26; i++) queue_word(ACT_KEY_BYTE, letter_ascii(deck[i]));
          counted += 26;
        end else begin
          key_len = $urandom_range(12);
          for (int i = 0; i < key_len; i++) begin
            if ($urandom_range(9) == 0) begin
              queue_word(ACT_KEY_BYTE, 8'($urandom));
              counted++;
            end else begin
              queue_word(ACT_KEY_BYTE, letter_ascii(letter_t'($urandom_range(25))));
              counted++;
            end
          end
        end
        // Leave out end of key now and then: the following text is dropped
        if (kind != 2) begin
          queue_word(ACT_END_KEY, 8'($urandom));
          counted++;
        end
      end
      text_len = $urandom_range(1, 24);
      prev     = NOT_LETTER;
      for (int i = 0; i < text_len; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          queue_word(ACT_TEXT_BYTE, 8'($urandom));
          counted++;
        end else if (r < 11) begin
          queue_word(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 8'($urandom));
          counted++;
        end else begin
          if (r < 25 && prev != NOT_LETTER) l = prev;
          else l = letter_t'($urandom_range(25));
          prev = l;
          queue_word(ACT_TEXT_BYTE, letter_ascii(l));
          counted++;
        end
      end
      if ($urandom_range(5) != 0) begin
        queue_word(ACT_END_TEXT, 8'($urandom));
        counted++;
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the backlog and every due digraph, then let the block settle
    while (word_backlog.size() != 0 || s_axis_tvalid || cipher_due.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (errors == 0 && cipher_due.size() == 0) begin
      $display("tb_playfair_encipher: clean");
    end else begin
      $display("tb_playfair_encipher: errors");
    end
    $finish;
  end

endmodule

// ===== playfair_encipher.f =====
sv/pf_pkg.sv
sv/pf_front.sv
sv/pf_queue.sv
sv/pf_back.sv
sv/playfair_encipher.sv
sv/pf_checker.sv
sim/tb_playfair_encipher.sv
